### rtl/core/tbsl_pkg.sv
`timescale 1ns / 1ps

package tbsl_pkg;

    // Fixed field widths
    localparam int DATA_W      = 32;
    localparam int COUNT_OUT_W = 6;
    localparam int NUM_BUFS    = 3;
    localparam int BUF_IDX_W   = 2;

    // Item function codes
    localparam logic FUNC_LOG   = 1'b0;
    localparam logic FUNC_FETCH = 1'b1;

    // Register indexes
    localparam int CFG_LOG_ENABLE = 0;

    typedef logic [BUF_IDX_W-1:0] buf_idx_t;

    // One stored sample record
    typedef struct packed {
        logic [DATA_W-1:0] err_flags;
        logic [DATA_W-1:0] warn_flags;
        logic [DATA_W-1:0] bus_voltage;
        logic [DATA_W-1:0] bus_current;
        logic [DATA_W-1:0] phase_a;
        logic [DATA_W-1:0] phase_b;
        logic [DATA_W-1:0] phase_c;
        logic [DATA_W-1:0] angle_sine;
        logic [DATA_W-1:0] angle_cosine;
        logic [DATA_W-1:0] volt_magnitude;
        logic [DATA_W-1:0] volt_angle;
    } record_t;

    typedef enum logic {
        ST_IDLE,
        ST_STREAM
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic do_log;
        logic do_fetch;
        logic advance;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic last;
    } status_t;

    // Buffer one place ahead, mod 3
    function automatic buf_idx_t buf_plus1(input buf_idx_t b);
        buf_idx_t r;
        case (b)
            2'd0:    r = 2'd1;
            2'd1:    r = 2'd2;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

    // Buffer two places ahead, mod 3
    function automatic buf_idx_t buf_plus2(input buf_idx_t b);
        buf_idx_t r;
        case (b)
            2'd0:    r = 2'd2;
            2'd1:    r = 2'd0;
            default: r = 2'd1;
        endcase
        return r;
    endfunction

endpackage

### rtl/core/tbsl_ram.sv
`timescale 1ns / 1ps

module tbsl_ram #(
    parameter int WIDTH  = 352,
    parameter int DEPTH  = 96,
    parameter int ADDR_W = 7
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

### rtl/core/tbsl_ctrl.sv
`timescale 1ns / 1ps

module tbsl_ctrl
    import tbsl_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  logic    in_func,
    output logic    in_stall,
    output logic    out_valid,
    input  logic    out_stall,
    output cmd_t    cmd,
    input  status_t status
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_func == FUNC_FETCH)
                begin
                    state_next = ST_STREAM;
                end
            end
            ST_STREAM:
            begin
                if (!out_stall && status.last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        in_stall     = 1'b1;
        out_valid    = 1'b0;
        cmd.do_log   = 1'b0;
        cmd.do_fetch = 1'b0;
        cmd.advance  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall     = 1'b0;
                cmd.do_log   = in_valid && (in_func == FUNC_LOG);
                cmd.do_fetch = in_valid && (in_func == FUNC_FETCH);
            end
            ST_STREAM:
            begin
                out_valid   = 1'b1;
                cmd.advance = !out_stall;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

endmodule

### rtl/core/tbsl_dpath.sv
`timescale 1ns / 1ps

module tbsl_dpath
    import tbsl_pkg::*;
#(
    parameter int SAMPLES_PER_BUFFER = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   log_enable,
    input  cmd_t                   cmd,
    output status_t                status,
    input  record_t                in_rec,
    output logic [DATA_W-1:0]      first_index,
    output logic [COUNT_OUT_W-1:0] count,
    output record_t                out_rec
);

    localparam int DEPTH  = NUM_BUFS * SAMPLES_PER_BUFFER;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(SAMPLES_PER_BUFFER + 1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(SAMPLES_PER_BUFFER);

    buf_idx_t          primary_reg, primary_next;
    logic [DATA_W-1:0] total_reg, total_next;
    logic [CNT_W-1:0]  fill_reg [NUM_BUFS];
    logic [CNT_W-1:0]  fill_next [NUM_BUFS];
    logic [DATA_W-1:0] stamp_reg [NUM_BUFS];
    logic [DATA_W-1:0] stamp_next [NUM_BUFS];
    buf_idx_t          fbuf_reg, fbuf_next;
    logic [CNT_W-1:0]  fcnt_reg, fcnt_next;
    logic [DATA_W-1:0] fstamp_reg, fstamp_next;
    logic [CNT_W-1:0]  k_reg, k_next;
    logic              empty_reg, empty_next;

    buf_idx_t          log_buf;
    logic [CNT_W-1:0]  log_slot;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    record_t           rd_rec;
    logic              last;

    // Start address of a buffer in the record memory
    function automatic logic [ADDR_W-1:0] buf_base(input buf_idx_t b);
        logic [ADDR_W-1:0] r;
        case (b)
            2'd0:    r = '0;
            2'd1:    r = ADDR_W'(SAMPLES_PER_BUFFER);
            default: r = ADDR_W'(2 * SAMPLES_PER_BUFFER);
        endcase
        return r;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            primary_reg <= '0;
            total_reg   <= '0;
            for (int i = 0; i < NUM_BUFS; i++)
            begin
                fill_reg[i]  <= '0;
                stamp_reg[i] <= '0;
            end
            fbuf_reg   <= '0;
            fcnt_reg   <= '0;
            fstamp_reg <= '0;
            k_reg      <= '0;
            empty_reg  <= 1'b0;
        end
        else
        begin
            primary_reg <= primary_next;
            total_reg   <= total_next;
            for (int i = 0; i < NUM_BUFS; i++)
            begin
                fill_reg[i]  <= fill_next[i];
                stamp_reg[i] <= stamp_next[i];
            end
            fbuf_reg   <= fbuf_next;
            fcnt_reg   <= fcnt_next;
            fstamp_reg <= fstamp_next;
            k_reg      <= k_next;
            empty_reg  <= empty_next;
        end
    end

    // Last record of the run shown now
    assign last = empty_reg || (k_reg + CNT_W'(1) == fcnt_reg);
    assign status.last = last;

    // Log target: primary, or reserve when primary is full
    always_comb
    begin
        log_buf  = primary_reg;
        if (fill_reg[primary_reg] >= FULL)
        begin
            log_buf = buf_plus1(primary_reg);
        end
        log_slot = fill_reg[log_buf];
        wr_en    = cmd.do_log && log_enable && (log_slot < FULL);
        wr_addr  = buf_base(log_buf) + ADDR_W'(log_slot);
    end

    // State updates for log and fetch
    always_comb
    begin
        primary_next = primary_reg;
        total_next   = total_reg;
        for (int i = 0; i < NUM_BUFS; i++)
        begin
            fill_next[i]  = fill_reg[i];
            stamp_next[i] = stamp_reg[i];
        end
        fbuf_next   = fbuf_reg;
        fcnt_next   = fcnt_reg;
        fstamp_next = fstamp_reg;
        k_next      = k_reg;
        empty_next  = empty_reg;

        if (cmd.do_log && log_enable)
        begin
            total_next = total_reg + DATA_W'(1);
            if (wr_en)
            begin
                fill_next[log_buf]  = log_slot + CNT_W'(1);
                stamp_next[log_buf] = total_reg - DATA_W'(log_slot);
            end
        end

        if (cmd.do_fetch)
        begin
            fill_next[buf_plus2(primary_reg)] = '0;
            primary_next = buf_plus1(primary_reg);
            fbuf_next    = primary_reg;
            fcnt_next    = fill_reg[primary_reg];
            fstamp_next  = stamp_reg[primary_reg];
            k_next       = '0;
            empty_next   = (fill_reg[primary_reg] == '0);
        end
        else if (cmd.advance && !last)
        begin
            k_next = k_reg + CNT_W'(1);
        end
    end

    // Read address tracks the record shown in the next cycle
    always_comb
    begin
        if (cmd.do_fetch)
        begin
            rd_addr = buf_base(primary_reg);
        end
        else
        begin
            rd_addr = buf_base(fbuf_reg) + ADDR_W'(k_next);
        end
    end

    tbsl_ram #(
        .WIDTH  ($bits(record_t)),
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (in_rec),
        .rd_addr (rd_addr),
        .rd_data (rd_rec)
    );

    // Result fields; an empty buffer shows zeroed samples
    assign first_index = fstamp_reg;
    assign count       = COUNT_OUT_W'(fcnt_reg);
    assign out_rec     = empty_reg ? record_t'('0) : rd_rec;

endmodule

### rtl/core/triple_buffer_sample_logger_top.sv
`timescale 1ns / 1ps

// Channel   Handshake              Payload
// input     in_valid / in_stall    func, err_flags .. voltage_angle
// output    out_valid / out_stall  buffer_first_index .. out_last
// config    APB write, pready=1    log_enable at every address
//
// A log transaction makes at most one record memory write.
// A fetch transaction streams its records at one per cycle while out_stall is
// low, from the registered read port of the record memory; an empty buffer
// gives a single result. No input is taken until the run's last result goes.
// Reset (rst_n, async) clears indexes, counts, stamps and log_enable.
// out_stall holds the current record; the read address holds with it.

module triple_buffer_sample_logger_top
    import tbsl_pkg::*;
#(
    parameter int SAMPLES_PER_BUFFER = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [1:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,

    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   func,
    input  logic [DATA_W-1:0]      err_flags,
    input  logic [DATA_W-1:0]      warn_flags,
    input  logic [DATA_W-1:0]      bus_voltage,
    input  logic [DATA_W-1:0]      bus_current,
    input  logic [DATA_W-1:0]      phase_a_current,
    input  logic [DATA_W-1:0]      phase_b_current,
    input  logic [DATA_W-1:0]      phase_c_current,
    input  logic [DATA_W-1:0]      angle_sine,
    input  logic [DATA_W-1:0]      angle_cosine,
    input  logic [DATA_W-1:0]      voltage_magnitude,
    input  logic [DATA_W-1:0]      voltage_angle,

    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [DATA_W-1:0]      buffer_first_index,
    output logic [COUNT_OUT_W-1:0] buffer_count,
    output logic [DATA_W-1:0]      out_err_flags,
    output logic [DATA_W-1:0]      out_warn_flags,
    output logic [DATA_W-1:0]      out_bus_voltage,
    output logic [DATA_W-1:0]      out_bus_current,
    output logic [DATA_W-1:0]      out_phase_a,
    output logic [DATA_W-1:0]      out_phase_b,
    output logic [DATA_W-1:0]      out_phase_c,
    output logic [2*DATA_W-1:0]    out_angle_pair,
    output logic [2*DATA_W-1:0]    out_voltage_pair,
    output logic                   out_last
);

    logic    log_enable_reg, log_enable_next;
    logic    cfg_wr;
    cmd_t    cmd;
    status_t status;
    record_t in_rec;
    record_t out_rec;

    // Config register; the single register decodes at every address
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        log_enable_next = log_enable_reg;
        if (cfg_wr && paddr[1:0] == 2'(CFG_LOG_ENABLE * 4))
        begin
            log_enable_next = pwdata[0];
        end
        else if (cfg_wr)
        begin
            log_enable_next = pwdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            log_enable_reg <= 1'b0;
        end
        else
        begin
            log_enable_reg <= log_enable_next;
        end
    end

    assign prdata = {31'b0, log_enable_reg};

    // Pack the sample record
    always_comb
    begin
        in_rec.err_flags      = err_flags;
        in_rec.warn_flags     = warn_flags;
        in_rec.bus_voltage    = bus_voltage;
        in_rec.bus_current    = bus_current;
        in_rec.phase_a        = phase_a_current;
        in_rec.phase_b        = phase_b_current;
        in_rec.phase_c        = phase_c_current;
        in_rec.angle_sine     = angle_sine;
        in_rec.angle_cosine   = angle_cosine;
        in_rec.volt_magnitude = voltage_magnitude;
        in_rec.volt_angle     = voltage_angle;
    end

    tbsl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_func   (func),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .status    (status)
    );

    tbsl_dpath #(
        .SAMPLES_PER_BUFFER (SAMPLES_PER_BUFFER)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .log_enable  (log_enable_reg),
        .cmd         (cmd),
        .status      (status),
        .in_rec      (in_rec),
        .first_index (buffer_first_index),
        .count       (buffer_count),
        .out_rec     (out_rec)
    );

    // Unpack the result record
    assign out_err_flags    = out_rec.err_flags;
    assign out_warn_flags   = out_rec.warn_flags;
    assign out_bus_voltage  = out_rec.bus_voltage;
    assign out_bus_current  = out_rec.bus_current;
    assign out_phase_a      = out_rec.phase_a;
    assign out_phase_b      = out_rec.phase_b;
    assign out_phase_c      = out_rec.phase_c;
    assign out_angle_pair   = {out_rec.angle_sine, out_rec.angle_cosine};
    assign out_voltage_pair = {out_rec.volt_magnitude, out_rec.volt_angle};
    assign out_last         = status.last;

endmodule
